>>> rtl/sclt_pkg.sv
// ----------------------------------------------------------------------------
// sclt_pkg
// Shared types, constants and constant-divide helpers for the SCL timing
// calculator.
// ----------------------------------------------------------------------------
package sclt_pkg;

  localparam int CLK_W  = 26;
  localparam int RISE_W = 10;
  localparam int TOP_W  = 22;
  localparam int REQ_W  = 26;
  localparam int DIV_W  = 8;
  localparam int ACT_W  = 23;
  localparam int LOW_W  = 16;
  localparam int MIN_W  = 13;
  localparam int KHZ_W  = 17;
  localparam int CYC_W  = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CORE_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_TIME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED  = 2'd2;

  localparam logic [CLK_W-1:0]  CORE_CLOCK_RST = 26'd24000000;
  localparam logic [RISE_W-1:0] RISE_TIME_RST  = 10'd300;
  localparam logic [TOP_W-1:0]  TOP_SPEED_RST  = 22'd1000000;

  localparam logic [CYC_W-1:0]  BASE_CYCLES  = 7'd10;
  localparam logic [16:0]       ROUND_UP_NS  = 17'd999;
  localparam logic [DIV_W-1:0]  DIV_MAX      = 8'd255;
  localparam logic [DIV_W:0]    LOW_BASE     = 9'd5;
  localparam logic [LOW_W-1:0]  LOW_SAT      = 16'd65535;
  localparam logic [ACT_W-1:0]  STD_MAX_HZ   = 23'd100000;
  localparam logic [ACT_W-1:0]  FAST_MAX_HZ  = 23'd400000;
  localparam logic [MIN_W-1:0]  MIN_LOW_STD  = 13'd4700;
  localparam logic [MIN_W-1:0]  MIN_LOW_FAST = 13'd1300;
  localparam logic [MIN_W-1:0]  MIN_LOW_FP   = 13'd500;
  localparam logic [27:0]       NS_PER_MS    = 28'd1000000;

  // derived values refresh through a short register chain after a write
  localparam logic [2:0] SETTLE_CYCLES = 3'd5;

  // exact floor division for x < 2**27 by multiply with rounded-up reciprocal
  localparam logic [27:0] RECIP_1E3 = 28'd137438954;
  localparam logic [27:0] RECIP_1E6 = 28'd140737489;

  typedef struct packed {
    logic [KHZ_W-1:0] khz;
    logic [CYC_W-1:0] rise_cyc;
    logic [CYC_W-1:0] overhead;
  } derived_t;

  function automatic logic [KHZ_W-1:0] div_1e3(input logic [26:0] x);
    logic [54:0] p;
    p = 55'(x) * 55'(RECIP_1E3);
    return p[53:37];
  endfunction

  function automatic logic [CYC_W-1:0] div_1e6(input logic [26:0] x);
    logic [54:0] p;
    p = 55'(x) * 55'(RECIP_1E6);
    return p[53:47];
  endfunction

endpackage

>>> rtl/sclt_if.sv
// ----------------------------------------------------------------------------
// sclt_in_if / sclt_out_if
// Valid/ready channels for requests and timing results.
// ----------------------------------------------------------------------------
interface sclt_in_if import sclt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] requested_hz;
  modport source (output valid, output requested_hz, input ready);
  modport sink   (input valid, input requested_hz, output ready);
endinterface

interface sclt_out_if import sclt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIV_W-1:0] divider;
  logic [ACT_W-1:0] actual_hz;
  logic [LOW_W-1:0] low_time_ns;
  logic [MIN_W-1:0] min_low_ns;
  logic             in_spec;
  modport source (output valid, output divider, output actual_hz, output low_time_ns,
                  output min_low_ns, output in_spec, input ready);
  modport sink   (input valid, input divider, input actual_hz, input low_time_ns,
                  input min_low_ns, input in_spec, output ready);
endinterface

>>> rtl/i2c_scl_timing_calculator_unit.sv
// ----------------------------------------------------------------------------
// i2c_scl_timing_calculator_unit
// SCL divider, real frequency, low time and spec check per requested rate.
//
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------------
//  in_chan  | in  | requested_hz
//  out_chan | out | divider, actual_hz, low_time_ns, min_low_ns, in_spec
//  cfg_*    | in  | we, index, wdata (core clock, rise time, top speed)
//
// one transfer per cycle while the output is not stalled and the config has
// settled; stages: 5 quotient, 2 divider, 12 shared-depth for frequency and
// low time, then the output register; reset, and every config write,
// hold in_chan.ready low while the derived clock values refresh
// a stalled output freezes the whole pipeline; nothing is dropped
// ----------------------------------------------------------------------------
module i2c_scl_timing_calculator_unit import sclt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  sclt_in_if.sink              in_chan,
  sclt_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CLK_W-1:0]     cfg_wdata
);

  logic [TOP_W-1:0] top_hz;
  derived_t         drv;
  logic             settled;
  logic             en;

  // current core clock is the numerator of the first and second divide
  logic [CLK_W-1:0] core_hz;

  sclt_cfg u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .core_hz, .top_hz, .drv, .settled
  );

  logic out_v_r;
  assign en = !out_v_r || out_chan.ready;
  assign in_chan.ready = en && settled;

  // request quotient, saturated at 1023
  logic       req_zero, req_sat;
  logic       d1_v;
  logic [9:0] d1_q;
  logic [1:0] d1_sb;

  assign req_zero = (in_chan.requested_hz == '0);
  assign req_sat  = (REQ_W'(core_hz[CLK_W-1:10]) >= in_chan.requested_hz);

  sclt_divpipe #(.NW(CLK_W), .DW(REQ_W), .QW(10), .BPS(2), .SW(2)) u_div_req (
    .clk, .rst_n, .en,
    .in_valid (in_chan.valid && in_chan.ready),
    .in_num   (req_sat ? '0 : core_hz),
    .in_den   (in_chan.requested_hz),
    .in_sb    ({req_zero, req_sat}),
    .out_valid(d1_v),
    .out_quo  (d1_q),
    .out_sb   (d1_sb)
  );

  // baud divider
  logic             b_v_r;
  logic [DIV_W-1:0] b_div_r, b_div_nxt;

  always_comb begin
    logic [9:0]  t;
    logic [10:0] v;
    t = d1_sb[0] ? 10'h3FF : d1_q;
    v = '0;
    b_div_nxt = '0;
    if (!d1_sb[1] && t > 10'(drv.overhead)) begin
      v = (11'(t) - 11'(drv.overhead) + 11'd1) >> 1;
      b_div_nxt = (v > 11'(DIV_MAX)) ? DIV_MAX : v[DIV_W-1:0];
    end
  end

  // frequency denominator and low time numerator
  logic             c_v_r;
  logic [DIV_W-1:0] c_div_r;
  logic [9:0]       c_den_r;
  logic [27:0]      c_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= d1_v;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_div_r <= b_div_nxt;
      c_div_r <= b_div_r;
      c_den_r <= 10'(BASE_CYCLES) + {1'b0, b_div_r, 1'b0} + 10'(drv.rise_cyc);
      c_num_r <= 28'(LOW_BASE + 9'(b_div_r)) * NS_PER_MS;
    end
  end

  logic low_sat;
  assign low_sat = (drv.khz == '0) || (KHZ_W'(c_num_r[27:16]) >= drv.khz);

  logic             d2_v, d3_v;
  logic [23:0]      d2_q, d3_q;
  logic [DIV_W-1:0] d2_sb;
  logic             d3_sb;

  sclt_divpipe #(.NW(CLK_W), .DW(10), .QW(24), .BPS(2), .SW(DIV_W)) u_div_hz (
    .clk, .rst_n, .en,
    .in_valid (c_v_r),
    .in_num   (core_hz),
    .in_den   (c_den_r),
    .in_sb    (c_div_r),
    .out_valid(d2_v),
    .out_quo  (d2_q),
    .out_sb   (d2_sb)
  );

  sclt_divpipe #(.NW(28), .DW(KHZ_W), .QW(24), .BPS(2), .SW(1)) u_div_low (
    .clk, .rst_n, .en,
    .in_valid (c_v_r),
    .in_num   (low_sat ? '0 : c_num_r),
    .in_den   (drv.khz),
    .in_sb    (low_sat),
    .out_valid(d3_v),
    .out_quo  (d3_q),
    .out_sb   (d3_sb)
  );

  // band check and output register
  logic [ACT_W-1:0] act;
  logic [LOW_W-1:0] low;
  logic [MIN_W-1:0] min_low;
  logic [DIV_W-1:0] o_div_r;
  logic [ACT_W-1:0] o_act_r;
  logic [LOW_W-1:0] o_low_r;
  logic [MIN_W-1:0] o_min_r;
  logic             o_spec_r;

  always_comb begin
    act = d2_q[ACT_W-1:0];
    low = d3_sb ? LOW_SAT : d3_q[LOW_W-1:0];
    if (act <= STD_MAX_HZ) begin
      min_low = MIN_LOW_STD;
    end else if (act <= FAST_MAX_HZ) begin
      min_low = MIN_LOW_FAST;
    end else begin
      min_low = MIN_LOW_FP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= d2_v && d3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_div_r  <= d2_sb;
      o_act_r  <= act;
      o_low_r  <= low;
      o_min_r  <= min_low;
      o_spec_r <= (act <= ACT_W'(top_hz)) && (low >= LOW_W'(min_low));
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.divider     = o_div_r;
  assign out_chan.actual_hz   = o_act_r;
  assign out_chan.low_time_ns = o_low_r;
  assign out_chan.min_low_ns  = o_min_r;
  assign out_chan.in_spec     = o_spec_r;

endmodule

>>> rtl/sclt_cfg.sv
// ----------------------------------------------------------------------------
// sclt_cfg
// Configuration registers and the register chain that derives core kHz,
// rise cycles and fixed overhead from them.
// ----------------------------------------------------------------------------
module sclt_cfg import sclt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CLK_W-1:0]     cfg_wdata,
  output logic [CLK_W-1:0]     core_hz,
  output logic [TOP_W-1:0]     top_hz,
  output derived_t             drv,
  output logic                 settled
);

  logic [CLK_W-1:0]  clk_hz_r;
  logic [RISE_W-1:0] rise_ns_r;
  logic [TOP_W-1:0]  top_hz_r;
  logic [2:0]        settle_r, settle_nxt;
  logic [KHZ_W-1:0]  khz_r;
  logic [CYC_W-1:0]  mhz_r;
  logic [16:0]       prod_r;
  logic [CYC_W-1:0]  rise_cyc_r;
  logic [CYC_W-1:0]  overhead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r  <= CORE_CLOCK_RST;
      rise_ns_r <= RISE_TIME_RST;
      top_hz_r  <= TOP_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CORE_CLOCK: clk_hz_r  <= cfg_wdata;
        REG_RISE_TIME:  rise_ns_r <= cfg_wdata[RISE_W-1:0];
        REG_TOP_SPEED:  top_hz_r  <= cfg_wdata[TOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    settle_nxt = settle_r;
    if (cfg_we) begin
      settle_nxt = SETTLE_CYCLES;
    end else if (settle_r != 3'd0) begin
      settle_nxt = settle_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_CYCLES;
    end else begin
      settle_r <= settle_nxt;
    end
  end

  // free-running chain of multiply stages, ending in an add for the overhead
  always_ff @(posedge clk) begin
    khz_r      <= div_1e3(27'(clk_hz_r));
    mhz_r      <= div_1e6(27'(clk_hz_r));
    prod_r     <= 17'(mhz_r) * 17'(rise_ns_r) + ROUND_UP_NS;
    rise_cyc_r <= CYC_W'(div_1e3(27'(prod_r)));
    overhead_r <= BASE_CYCLES + rise_cyc_r;
  end

  assign core_hz      = clk_hz_r;
  assign top_hz       = top_hz_r;
  assign drv.khz      = khz_r;
  assign drv.rise_cyc = rise_cyc_r;
  assign drv.overhead = overhead_r;
  assign settled      = (settle_r == 3'd0);

endmodule

>>> rtl/sclt_divpipe.sv
// ----------------------------------------------------------------------------
// sclt_divpipe
// Pipelined restoring divider, BPS quotient bits per stage, with valid bits
// and a sideband that travel alongside. Needs num < den * 2**QW.
// ----------------------------------------------------------------------------
module sclt_divpipe #(
  parameter int NW  = 26,
  parameter int DW  = 26,
  parameter int QW  = 10,
  parameter int BPS = 2,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_sb,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_sb
);

  localparam int NST = QW / BPS;
  localparam int CW  = DW + QW;

  logic [NST-1:0] v_r;
  logic [NW-1:0]  rem_r [NST];
  logic [QW-1:0]  q_r   [NST];
  logic [DW-1:0]  den_r [NST];
  logic [SW-1:0]  sb_r  [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic          v_i;
    logic [NW-1:0] rem_i, rem_w;
    logic [QW-1:0] q_i, q_w;
    logic [DW-1:0] den_i;
    logic [SW-1:0] sb_i;

    if (s == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = in_num;
      assign q_i   = '0;
      assign den_i = in_den;
      assign sb_i  = in_sb;
    end else begin : g_next
      assign v_i   = v_r[s-1];
      assign rem_i = rem_r[s-1];
      assign q_i   = q_r[s-1];
      assign den_i = den_r[s-1];
      assign sb_i  = sb_r[s-1];
    end

    always_comb begin
      logic [CW-1:0] sh;
      rem_w = rem_i;
      q_w   = q_i;
      for (int b = 0; b < BPS; b++) begin
        sh = CW'(den_i) << (QW - 1 - (s * BPS + b));
        if (CW'(rem_w) >= sh) begin
          rem_w = NW'(CW'(rem_w) - sh);
          q_w   = {q_w[QW-2:0], 1'b1};
        end else begin
          q_w   = {q_w[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_w;
        q_r[s]   <= q_w;
        den_r[s] <= den_i;
        sb_r[s]  <= sb_i;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_quo   = q_r[NST-1];
  assign out_sb    = sb_r[NST-1];

endmodule

>>> rtl/sclt_checker.sv
// ----------------------------------------------------------------------------
// sclt_checker
// Port-level checks on the SCL timing calculator, bound to the top level.
// ----------------------------------------------------------------------------
module sclt_checker import sclt_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             cfg_we,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DIV_W-1:0] divider,
  input logic [ACT_W-1:0] actual_hz,
  input logic [MIN_W-1:0] min_low_ns
);

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(divider) && $stable(actual_hz))
    else $error("result changed while stalled");

  // derived clock values refresh before the next request is taken
  a_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("request taken during config refresh");

  a_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> min_low_ns == MIN_LOW_STD || min_low_ns == MIN_LOW_FAST ||
                  min_low_ns == MIN_LOW_FP)
    else $error("bad minimum low time");

  a_std: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && actual_hz <= STD_MAX_HZ |-> min_low_ns == MIN_LOW_STD)
    else $error("standard band mismatch");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind i2c_scl_timing_calculator_unit sclt_checker u_sclt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .cfg_we     (cfg_we),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .divider    (out_chan.divider),
  .actual_hz  (out_chan.actual_hz),
  .min_low_ns (out_chan.min_low_ns)
);

>>> tb/sclt_tb_if.sv
// ----------------------------------------------------------------------------
// sclt_tb_if
// Stand-in note: the channel interfaces come from rtl/sclt_if.sv; this file
// holds the small bundle the bench uses to keep track of run health.
// ----------------------------------------------------------------------------
interface sclt_tb_stat_if ();
  int unsigned errors;
  int unsigned cycles;
endinterface

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the SCL timing calculator: each requested frequency is predicted
// in SV (divider, real frequency, low time, band minimum, spec flag) and the
// results are compared in order, under random gaps, stalls and config changes.
// ----------------------------------------------------------------------------
module testbench;
  import sclt_pkg::*;

  typedef struct packed {
    logic [DIV_W-1:0] divider;
    logic [ACT_W-1:0] actual_hz;
    logic [LOW_W-1:0] low_time_ns;
    logic [MIN_W-1:0] min_low_ns;
    logic             in_spec;
  } timing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CORE_CLOCK;
  logic [CLK_W-1:0] cfg_wdata = '0;

  sclt_in_if  in_chan ();
  sclt_out_if out_chan ();
  sclt_tb_stat_if stat ();

  i2c_scl_timing_calculator_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int LATENCY = 20;

  logic [CLK_W-1:0]  core_hz;
  logic [RISE_W-1:0] rise_ns;
  logic [TOP_W-1:0]  top_hz;
  timing_t timing_q[$];
  int  hold_off = 0;
  bit  rx_stall_burst = 1'b0;

  initial begin
    in_chan.valid = 1'b0;
    in_chan.requested_hz = '0;
    out_chan.ready = 1'b0;
    stat.errors = 0;
    stat.cycles = 0;
    core_hz = CORE_CLOCK_RST;
    rise_ns = RISE_TIME_RST;
    top_hz  = TOP_SPEED_RST;
  end

  function automatic timing_t predict_timing(logic [REQ_W-1:0] req);
    timing_t t;
    longint unsigned rise_cyc, total, overhead, d, act, khz, ns;
    rise_cyc = ((longint'(core_hz) / 1000000) * rise_ns + 999) / 1000;
    d = 0;
    if (req != 0) begin
      total = longint'(core_hz) / req;
      overhead = 10 + rise_cyc;
      if (total > overhead) begin
        d = (total - overhead + 1) / 2;
        if (d > 255) d = 255;
      end
    end
    act = longint'(core_hz) / (10 + 2 * d + rise_cyc);
    khz = longint'(core_hz) / 1000;
    if (khz == 0) ns = 65535;
    else begin
      ns = ((5 + d) * 1000000) / khz;
      if (ns > 65535) ns = 65535;
    end
    t.divider = d[DIV_W-1:0];
    t.actual_hz = act[ACT_W-1:0];
    t.low_time_ns = ns[LOW_W-1:0];
    if (act <= 100000) t.min_low_ns = MIN_LOW_STD;
    else if (act <= 400000) t.min_low_ns = MIN_LOW_FAST;
    else t.min_low_ns = MIN_LOW_FP;
    t.in_spec = (act <= top_hz) && (ns >= t.min_low_ns);
    return t;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, stat.cycles);
    stat.errors++;
  endtask

  // cycle counter and timeout
  always @(posedge clk) begin
    stat.cycles <= stat.cycles + 1;
    if (stat.cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result checker: sample at the rising edge
  always @(posedge clk) begin
    timing_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (timing_q.size() == 0) begin
        report("unexpected result transfer", 64'(1), 64'(0));
      end else begin
        want = timing_q.pop_front();
        if (out_chan.divider !== want.divider)
          report("divider", 64'(out_chan.divider), 64'(want.divider));
        if (out_chan.actual_hz !== want.actual_hz)
          report("actual_hz", 64'(out_chan.actual_hz), 64'(want.actual_hz));
        if (out_chan.low_time_ns !== want.low_time_ns)
          report("low_time_ns", 64'(out_chan.low_time_ns), 64'(want.low_time_ns));
        if (out_chan.min_low_ns !== want.min_low_ns)
          report("min_low_ns", 64'(out_chan.min_low_ns), 64'(want.min_low_ns));
        if (out_chan.in_spec !== want.in_spec)
          report("in_spec", 64'(out_chan.in_spec), 64'(want.in_spec));
      end
    end
  end

  // receiver: random stalls, a long hold-off on request
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_chan.ready = 1'b0;
        hold_off--;
      end else if (!rx_stall_burst) begin
        out_chan.ready = 1'b1;
      end else if (out_chan.ready && out_chan.valid) begin
        // new draw after each transfer
        gap = $urandom_range(0, 10);
        if (gap > 0) begin
          out_chan.ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_chan.ready = 1'b1;
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  bit tx_gaps = 1'b0;

  task automatic send_request(logic [REQ_W-1:0] req);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.requested_hz = req;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    timing_q.push_back(predict_timing(req));
    @(negedge clk);
    in_chan.valid = 1'b0;
  endtask

  task automatic drain;
    while (timing_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CLK_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_CORE_CLOCK: core_hz = val;
      REG_RISE_TIME:  rise_ns = val[RISE_W-1:0];
      REG_TOP_SPEED:  top_hz  = val[TOP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned clk_hz, int unsigned rise, int unsigned top);
    drain();
    write_reg(REG_CORE_CLOCK, CLK_W'(clk_hz));
    write_reg(REG_RISE_TIME, CLK_W'(rise));
    write_reg(REG_TOP_SPEED, CLK_W'(top));
  endtask

  function automatic logic [REQ_W-1:0] random_request();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return REQ_W'($urandom_range(1, 200));
      2: return REQ_W'($urandom_range(0, 64000000));
      3: return REQ_W'($urandom);
      default: return REQ_W'($urandom_range(10000, 4000000));
    endcase
  endfunction

  task automatic test_directed;
    send_request(0);
    send_request(1);
    send_request(26'h3ffffff);
    send_request(64000000);
    send_request(100000);
    send_request(400000);
    send_request(1000000);
    send_request(1200000);
    send_request(3000000);
    send_request(50);
    send_request(26'h2aaaaaa);
    send_request(26'h1555555);
    set_config(1000000, 0, 100000);
    send_request(1);
    send_request(5000);
    send_request(100000);
    set_config(64000000, 1000, 4000000);
    send_request(1);
    send_request(400000);
    send_request(1000000);
    send_request(4000000);
    set_config(26'h3ffffff, 10'h3ff, 22'h3fffff);
    send_request(100000);
    send_request(1);
  endtask

  task automatic test_random(int n);
    repeat (n) send_request(random_request());
  endtask

  task automatic test_backpressure;
    // long receiver hold-off while requests keep coming
    tx_gaps = 1'b0;
    hold_off = 300;
    repeat (80) send_request(random_request());
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    set_config(24000000, 300, 1000000);
    tx_gaps = 1'b1;
    rx_stall_burst = 1'b1;
    test_random(400);
    set_config($urandom_range(1000000, 64000000), $urandom_range(0, 1000),
               $urandom_range(100000, 4000000));
    test_backpressure();
    tx_gaps = 1'b1;
    test_random(300);
    set_config(1000000, 1000, 4000000);
    rx_stall_burst = 1'b0;
    tx_gaps = 1'b0;
    test_random(300);
    set_config(8000000, 0, 400000);
    tx_gaps = 1'b1;
    rx_stall_burst = 1'b1;
    test_random(300);
    set_config($urandom_range(1000000, 64000000), $urandom_range(0, 1000),
               $urandom_range(100000, 4000000));
    test_random(300);
    drain();
    if (stat.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
rtl/sclt_pkg.sv
rtl/sclt_if.sv
rtl/sclt_cfg.sv
rtl/sclt_divpipe.sv
rtl/i2c_scl_timing_calculator_unit.sv
rtl/sclt_checker.sv
tb/sclt_tb_if.sv
tb/testbench.sv
